// File: src/rtc_raw_to_calendar_timestamp_assert.svh
// assertion macros used by the top rtc module
`ifndef RTC_RAW_TO_CALENDAR_TIMESTAMP_ASSERT_SVH
`define RTC_RAW_TO_CALENDAR_TIMESTAMP_ASSERT_SVH

// same-cycle implication
`define RTC_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("rtc assertion failed");

// next-cycle implication
`define RTC_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("rtc assertion failed");

`endif

// File: src/rtc_pkg.sv
package rtc_pkg;

    // configuration register indexes
    localparam logic CFG_BCD_MODE    = 1'b0;
    localparam logic CFG_TWELVE_HOUR = 1'b1;

    localparam int YDAYS_W = 17;
    localparam int MDAYS_W = 9;
    localparam int DAYS_W  = 17;
    localparam int TOD_W   = 20;

    localparam logic [11:0] YEAR_1900 = 12'd1900;
    localparam logic [11:0] YEAR_2000 = 12'd2000;
    localparam logic [11:0] YEAR_2100 = 12'd2100;
    localparam logic [11:0] YEAR_2200 = 12'd2200;
    localparam logic [11:0] YEAR_2300 = 12'd2300;
    localparam logic [11:0] YEAR_MIN  = 12'd1900;
    localparam logic [11:0] YEAR_MAX  = 12'd2355;
    localparam logic [7:0]  WINDOW_YR = 8'd70;

    localparam logic [TOD_W-1:0] SECS_PER_HOUR = 20'd3600;
    localparam logic [TOD_W-1:0] SECS_PER_MIN  = 20'd60;
    localparam logic [31:0]      SECS_PER_DAY  = 32'd86400;
    localparam logic [YDAYS_W-1:0] DAYS_PER_YEAR = 17'd365;

    typedef struct packed {
        logic [7:0] raw_second;
        logic [7:0] raw_minute;
        logic [7:0] raw_hour;
        logic [7:0] raw_weekday;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
        logic [7:0] raw_century;
    } t_in;

    typedef struct packed {
        logic [7:0]  second_out;
        logic [7:0]  minute_out;
        logic [7:0]  hour_out;
        logic [7:0]  weekday_out;
        logic [7:0]  day_out;
        logic [7:0]  month_out;
        logic [11:0] full_year;
        logic [31:0] seconds_since_2000;
    } t_out;

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] weekday;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
    } t_dec;

    typedef struct packed {
        logic [7:0]  second;
        logic [7:0]  minute;
        logic [7:0]  hour;
        logic [7:0]  weekday;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [11:0] full_year;
    } t_fields;

    typedef struct packed {
        t_fields    f;
        logic [3:0] month_lim;
    } t_cal;

    typedef struct packed {
        t_fields              f;
        logic [YDAYS_W-1:0]   year_days;
        logic [MDAYS_W-1:0]   month_days;
        logic [TOD_W-1:0]     tod;
    } t_part;

    typedef struct packed {
        t_fields             f;
        logic [DAYS_W-1:0]   days;
        logic [TOD_W-1:0]    tod;
    } t_sum;

    typedef struct packed {
        t_fields            f;
        logic [31:0]        day_secs;
        logic [TOD_W-1:0]   tod;
    } t_prod;

    function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic bcd);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]};
        return bcd ? 8'((tens << 3) + (tens << 1) + {4'd0, b[3:0]}) : b;
    endfunction

    // days in the months before the given one, non-leap year
    function automatic logic [MDAYS_W-1:0] month_start(input logic [3:0] m);
        logic [MDAYS_W-1:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: src/rtc_decode.sv
module rtc_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_bcd_mode,
    input  logic          i_twelve_hour,
    input  logic          i_valid,
    input  rtc_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output rtc_pkg::t_dec o_data,
    input  logic          i_stall
);

    logic          r_valid;
    rtc_pkg::t_dec r_data;
    rtc_pkg::t_dec n_data;
    logic [7:0]    w_hraw;
    logic [7:0]    w_hdec;
    logic          w_pm;
    logic          w_load;

    assign o_stall = r_valid && i_stall;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        // pm flag is stripped before decode in 12-hour mode
        w_pm   = i_twelve_hour && i_data.raw_hour[7];
        w_hraw = i_twelve_hour ? {1'b0, i_data.raw_hour[6:0]} : i_data.raw_hour;
        w_hdec = rtc_pkg::bcd_decode(w_hraw, i_bcd_mode);

        n_data.second  = rtc_pkg::bcd_decode(i_data.raw_second, i_bcd_mode);
        n_data.minute  = rtc_pkg::bcd_decode(i_data.raw_minute, i_bcd_mode);
        n_data.weekday = rtc_pkg::bcd_decode(i_data.raw_weekday, i_bcd_mode);
        n_data.day     = rtc_pkg::bcd_decode(i_data.raw_day, i_bcd_mode);
        n_data.month   = rtc_pkg::bcd_decode(i_data.raw_month, i_bcd_mode);
        n_data.year    = rtc_pkg::bcd_decode(i_data.raw_year, i_bcd_mode);
        n_data.century = rtc_pkg::bcd_decode(i_data.raw_century, i_bcd_mode);
        n_data.hour    = w_hdec;
        if (i_twelve_hour) begin
            if (w_pm && w_hdec < 8'd12) begin
                n_data.hour = w_hdec + 8'd12;
            end else if (!w_pm && w_hdec == 8'd12) begin
                n_data.hour = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/rtc_days.sv
module rtc_days (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rtc_pkg::t_dec i_data,
    output logic          o_stall,
    output logic          o_valid,
    output rtc_pkg::t_sum o_data,
    input  logic          i_stall
);

    // stage a: year and month clamp
    logic           r_va;
    rtc_pkg::t_cal  r_a;
    rtc_pkg::t_cal  n_a;
    // stage b: year days, month days, time of day
    logic           r_vb;
    rtc_pkg::t_part r_b;
    rtc_pkg::t_part n_b;
    // stage c: total day count
    logic           r_vc;
    rtc_pkg::t_sum  r_c;
    rtc_pkg::t_sum  n_c;

    logic w_stall_a;
    logic w_stall_b;
    logic w_stall_c;

    logic [11:0] w_base;
    logic [8:0]  w_nyears;
    logic [9:0]  w_nplus;
    logic [1:0]  w_cent;
    logic        w_leap;

    assign w_stall_c = r_vc && i_stall;
    assign w_stall_b = r_vb && w_stall_c;
    assign w_stall_a = r_va && w_stall_b;
    assign o_stall   = w_stall_a;

    always_comb begin
        n_a.f.second  = i_data.second;
        n_a.f.minute  = i_data.minute;
        n_a.f.hour    = i_data.hour;
        n_a.f.weekday = i_data.weekday;
        n_a.f.day     = i_data.day;
        n_a.f.month   = i_data.month;
        case (i_data.century)
            8'd19:   w_base = rtc_pkg::YEAR_1900;
            8'd20:   w_base = rtc_pkg::YEAR_2000;
            8'd21:   w_base = rtc_pkg::YEAR_2100;
            default: w_base = (i_data.year >= rtc_pkg::WINDOW_YR) ? rtc_pkg::YEAR_1900
                                                                  : rtc_pkg::YEAR_2000;
        endcase
        n_a.f.full_year = w_base + {4'd0, i_data.year};
        n_a.month_lim   = (i_data.month > 8'd12) ? 4'd12 : i_data.month[3:0];
    end

    always_comb begin
        n_b.f = r_a.f;
        // whole years from 2000, none before it
        w_nyears = (r_a.f.full_year > rtc_pkg::YEAR_2000)
                   ? 9'(r_a.f.full_year - rtc_pkg::YEAR_2000) : 9'd0;
        w_nplus  = {1'b0, w_nyears} + 10'd3;
        // century years 2100, 2200, 2300 are not leap
        w_cent   = 2'(w_nyears >= 9'd101) + 2'(w_nyears >= 9'd201) + 2'(w_nyears >= 9'd301);
        n_b.year_days = 17'(w_nyears) * rtc_pkg::DAYS_PER_YEAR
                      + 17'(w_nplus[9:2]) - 17'(w_cent);
        w_leap = (r_a.f.full_year[1:0] == 2'd0)
              && (r_a.f.full_year != rtc_pkg::YEAR_1900)
              && (r_a.f.full_year != rtc_pkg::YEAR_2100)
              && (r_a.f.full_year != rtc_pkg::YEAR_2200)
              && (r_a.f.full_year != rtc_pkg::YEAR_2300);
        n_b.month_days = rtc_pkg::month_start(r_a.month_lim)
                       + 9'(w_leap && (r_a.month_lim > 4'd2));
        n_b.tod = 20'(r_a.f.hour) * rtc_pkg::SECS_PER_HOUR
                + 20'(r_a.f.minute) * rtc_pkg::SECS_PER_MIN
                + 20'(r_a.f.second);
    end

    always_comb begin
        n_c.f    = r_b.f;
        n_c.tod  = r_b.tod;
        // day - 1 is folded into the final subtract
        n_c.days = r_b.year_days + 17'(r_b.month_days) + 17'(r_b.f.day);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (!w_stall_a) begin
                r_va <= i_valid;
            end
            if (!w_stall_b) begin
                r_vb <= r_va;
            end
            if (!w_stall_c) begin
                r_vc <= r_vb;
            end
        end
        if (!w_stall_a && i_valid) begin
            r_a <= n_a;
        end
        if (!w_stall_b && r_va) begin
            r_b <= n_b;
        end
        if (!w_stall_c && r_vb) begin
            r_c <= n_c;
        end
    end

    assign o_valid = r_vc;
    assign o_data  = r_c;

endmodule

// File: src/rtc_stamp.sv
module rtc_stamp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rtc_pkg::t_sum i_data,
    output logic          o_stall,
    output logic          o_valid,
    output rtc_pkg::t_out o_data,
    input  logic          i_stall
);

    logic           r_vp;
    rtc_pkg::t_prod r_p;
    rtc_pkg::t_prod n_p;
    logic           r_vo;
    rtc_pkg::t_out  r_o;
    rtc_pkg::t_out  n_o;
    logic [33:0]    w_full;
    logic           w_stall_p;
    logic           w_stall_o;

    assign w_stall_o = r_vo && i_stall;
    assign w_stall_p = r_vp && w_stall_o;
    assign o_stall   = w_stall_p;

    always_comb begin
        w_full       = 34'(i_data.days) * 34'(rtc_pkg::SECS_PER_DAY);
        n_p.f        = i_data.f;
        n_p.tod      = i_data.tod;
        n_p.day_secs = w_full[31:0];
    end

    always_comb begin
        n_o.second_out  = r_p.f.second;
        n_o.minute_out  = r_p.f.minute;
        n_o.hour_out    = r_p.f.hour;
        n_o.weekday_out = r_p.f.weekday;
        n_o.day_out     = r_p.f.day;
        n_o.month_out   = r_p.f.month;
        n_o.full_year   = r_p.f.full_year;
        // subtract one day for the day-of-month offset, wraps mod 2^32
        n_o.seconds_since_2000 = r_p.day_secs - rtc_pkg::SECS_PER_DAY + 32'(r_p.tod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (!w_stall_p) begin
                r_vp <= i_valid;
            end
            if (!w_stall_o) begin
                r_vo <= r_vp;
            end
        end
        if (!w_stall_p && i_valid) begin
            r_p <= n_p;
        end
        if (!w_stall_o && r_vp) begin
            r_o <= n_o;
        end
    end

    assign o_valid = r_vo;
    assign o_data  = r_o;

endmodule

// File: src/rtc_raw_to_calendar_timestamp.sv
// raw rtc register snapshot to calendar fields and seconds since 2000
// input channel: i_valid / i_data / o_stall, one snapshot of eight raw bytes
// per transfer. output channel: o_valid / o_data / i_stall, one result per
// snapshot, in order.
// config: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 bcd mode, 1 twelve-hour mode); write only while the block is empty.
// pipeline: six register stages (decode, year, day and time partials, day
// sum, day multiply, final add and output register).
// throughput: one snapshot per cycle while o_stall is low;
// every stage holds its own valid bit.
// stall: i_stall holds the output register; the upstream stages keep
// filling their empty slots, and o_stall rises only once every stage
// holds a snapshot. nothing is dropped or repeated.
// reset: all valid bits clear, bcd mode goes to 1, twelve-hour mode to 0.
`include "rtc_raw_to_calendar_timestamp_assert.svh"

module rtc_raw_to_calendar_timestamp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic          i_cfg_wdata,
    input  logic          i_valid,
    input  rtc_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output rtc_pkg::t_out o_data,
    input  logic          i_stall
);

    logic          r_bcd_mode;
    logic          r_twelve_hour;

    logic          w_dec_valid;
    rtc_pkg::t_dec w_dec_data;
    logic          w_dec_stall;
    logic          w_sum_valid;
    rtc_pkg::t_sum w_sum_data;
    logic          w_sum_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcd_mode    <= 1'b1;
            r_twelve_hour <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rtc_pkg::CFG_BCD_MODE:    r_bcd_mode    <= i_cfg_wdata;
                rtc_pkg::CFG_TWELVE_HOUR: r_twelve_hour <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rtc_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bcd_mode    (r_bcd_mode),
        .i_twelve_hour (r_twelve_hour),
        .i_valid       (i_valid),
        .i_data        (i_data),
        .o_stall       (o_stall),
        .o_valid       (w_dec_valid),
        .o_data        (w_dec_data),
        .i_stall       (w_dec_stall)
    );

    rtc_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .i_data  (w_dec_data),
        .o_stall (w_dec_stall),
        .o_valid (w_sum_valid),
        .o_data  (w_sum_data),
        .i_stall (w_sum_stall)
    );

    rtc_stamp u_stamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .i_data  (w_sum_data),
        .o_stall (w_sum_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // the input only backs up when the whole pipe is full and held
    `RTC_ASSERT_NOW(a_stall_needs_full, i_clk, !i_rst_n, o_stall, o_valid && i_stall && w_sum_valid && w_dec_valid)
    `RTC_ASSERT_NOW(a_year_range, i_clk, !i_rst_n, o_valid, (o_data.full_year >= rtc_pkg::YEAR_MIN) && (o_data.full_year <= rtc_pkg::YEAR_MAX))
    `RTC_ASSERT_NEXT(a_reset_empties, i_clk, 1'b0, !i_rst_n, !o_valid && !w_sum_valid && !w_dec_valid)

endmodule

// File: test/rtc_raw_to_calendar_timestamp_tb.sv
module rtc_raw_to_calendar_timestamp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 350;
    localparam int TAIL_CYCLES    = 20;
    localparam rtc_pkg::t_out NO_WANT = '0;

    typedef struct packed {
        bit            bcd;
        bit            h12;
        bit            typed;
        rtc_pkg::t_in  raw;
        rtc_pkg::t_out want;
    } t_dir_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic          i_cfg_idx;
    logic          i_cfg_wdata;
    logic          i_valid;
    rtc_pkg::t_in  i_data;
    logic          o_stall;
    logic          o_valid;
    rtc_pkg::t_out o_data;
    logic          i_stall;

    // register copy used for prediction
    bit cfg_bcd = 1'b1;
    bit cfg_h12 = 1'b0;

    bit            had_error    = 1'b0;
    bit            hold_off_req = 1'b0;
    int            gap_pct      = 0;
    int            stall_pct    = 0;
    int            idle_cycles  = 0;
    bit            cur_typed;
    rtc_pkg::t_out cur_want;
    rtc_pkg::t_out due_calendars [$];

    int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    bit phase_bcd   [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    bit phase_h12   [5] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    int phase_gap   [5] = '{0, 20, 5, 10, 35};
    int phase_stall [5] = '{0, 20, 30, 50, 10};

    t_dir_row dir_tab [25] = '{
        // bcd, 24-hour
        '{1'b1, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h20},
          '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 12'd2000, 32'd0}},
        '{1'b1, 1'b0, 1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
          NO_WANT},
        // day zero wraps below the epoch
        '{1'b1, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h20},
          NO_WANT},
        '{1'b1, 1'b0, 1'b0, '{8'h59, 8'h59, 8'h23, 8'h07, 8'h31, 8'h12, 8'h99, 8'h00},
          NO_WANT},
        // month past december only clamps the day count
        '{1'b1, 1'b0, 1'b0, '{8'h30, 8'h45, 8'h10, 8'h03, 8'h15, 8'h15, 8'h24, 8'h20},
          NO_WANT},
        '{1'b1, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h05, 8'h01, 8'h03, 8'h24, 8'h20},
          NO_WANT},
        '{1'b1, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h03, 8'h00, 8'h21},
          NO_WANT},
        '{1'b1, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h03, 8'h00, 8'h20},
          NO_WANT},
        '{1'b1, 1'b0, 1'b0, '{8'h12, 8'h34, 8'h05, 8'h02, 8'h28, 8'h02, 8'h69, 8'h19},
          NO_WANT},
        '{1'b1, 1'b0, 1'b0, '{8'h12, 8'h34, 8'h05, 8'h02, 8'h28, 8'h02, 8'h69, 8'h22},
          NO_WANT},
        '{1'b1, 1'b0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h70, 8'h00},
          NO_WANT},
        // nibbles above nine
        '{1'b1, 1'b0, 1'b0, '{8'h5A, 8'hAF, 8'hFA, 8'h0B, 8'h9F, 8'h1A, 8'hA0, 8'h2F},
          NO_WANT},
        // binary, 24-hour
        '{1'b0, 1'b0, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
          '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd2000, 32'hFFFE_AE80}},
        '{1'b0, 1'b0, 1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
          NO_WANT},
        '{1'b0, 1'b0, 1'b0, '{8'd59, 8'd59, 8'd23, 8'd6, 8'd31, 8'd12, 8'd255, 8'd21},
          NO_WANT},
        '{1'b0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd70, 8'd19},
          NO_WANT},
        // bcd, 12-hour: midnight and noon, then other pm and odd hour bytes
        '{1'b1, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h12, 8'h00, 8'h01, 8'h01, 8'h00, 8'h20},
          '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 12'd2000, 32'd0}},
        '{1'b1, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h92, 8'h00, 8'h01, 8'h01, 8'h00, 8'h20},
          '{8'd0, 8'd0, 8'd12, 8'd0, 8'd1, 8'd1, 12'd2000, 32'd43200}},
        '{1'b1, 1'b1, 1'b0, '{8'h30, 8'h15, 8'h81, 8'h04, 8'h15, 8'h06, 8'h23, 8'h20},
          NO_WANT},
        '{1'b1, 1'b1, 1'b0, '{8'h30, 8'h15, 8'h91, 8'h04, 8'h15, 8'h06, 8'h23, 8'h20},
          NO_WANT},
        '{1'b1, 1'b1, 1'b0, '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h01, 8'h00, 8'h20},
          NO_WANT},
        '{1'b1, 1'b1, 1'b0, '{8'h00, 8'h00, 8'h80, 8'h00, 8'h01, 8'h01, 8'h00, 8'h20},
          NO_WANT},
        // binary, 12-hour
        '{1'b0, 1'b1, 1'b0, '{8'd1, 8'd2, 8'h8C, 8'd3, 8'd4, 8'd5, 8'd6, 8'd20},
          NO_WANT},
        '{1'b0, 1'b1, 1'b0, '{8'd1, 8'd2, 8'h8B, 8'd3, 8'd4, 8'd5, 8'd6, 8'd20},
          NO_WANT},
        '{1'b0, 1'b1, 1'b0, '{8'd1, 8'd2, 8'hFF, 8'd3, 8'd4, 8'd5, 8'd6, 8'd20},
          NO_WANT}
    };

    rtc_raw_to_calendar_timestamp DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    function automatic logic [7:0] from_bcd(logic [7:0] b, bit bcd);
        return bcd ? 8'(int'(b[7:4]) * 10 + int'(b[3:0])) : b;
    endfunction

    function automatic logic [7:0] to_reg(int v, bit bcd);
        return bcd ? 8'((v / 10) * 16 + v % 10) : 8'(v);
    endfunction

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic rtc_pkg::t_out calendar_of(rtc_pkg::t_in r, bit bcd, bit h12);
        rtc_pkg::t_out c;
        logic [7:0]    hr_byte;
        logic [7:0]    yr8;
        logic [7:0]    century;
        logic [31:0]   days;
        int unsigned   y;
        int unsigned   m;
        int unsigned   mon_lim;
        bit            pm;
        c.second_out  = from_bcd(r.raw_second, bcd);
        c.minute_out  = from_bcd(r.raw_minute, bcd);
        c.weekday_out = from_bcd(r.raw_weekday, bcd);
        c.day_out     = from_bcd(r.raw_day, bcd);
        c.month_out   = from_bcd(r.raw_month, bcd);
        hr_byte = r.raw_hour;
        pm = 1'b0;
        if (h12) begin
            pm = hr_byte[7];
            hr_byte[7] = 1'b0;
        end
        c.hour_out = from_bcd(hr_byte, bcd);
        if (h12 && pm && c.hour_out < 12)
            c.hour_out = c.hour_out + 8'd12;
        if (h12 && !pm && c.hour_out == 12)
            c.hour_out = 8'd0;
        yr8     = from_bcd(r.raw_year, bcd);
        century = from_bcd(r.raw_century, bcd);
        if (century >= 19 && century <= 21)
            c.full_year = 12'(int'(century) * 100 + int'(yr8));
        else if (yr8 >= 70)
            c.full_year = 12'(1900 + int'(yr8));
        else
            c.full_year = 12'(2000 + int'(yr8));
        // years before 2000 contribute nothing here
        days = '0;
        for (y = 2000; y < c.full_year; y++)
            days = days + (leap_year(y) ? 32'd366 : 32'd365);
        mon_lim = (c.month_out > 12) ? 12 : c.month_out;
        for (m = 1; m < mon_lim; m++) begin
            days = days + month_len[m - 1];
            if (m == 2 && leap_year(c.full_year))
                days = days + 32'd1;
        end
        days = days + 32'(c.day_out) - 32'd1;
        c.seconds_since_2000 = days * 32'd86400 + 32'(c.hour_out) * 32'd3600
                             + 32'(c.minute_out) * 32'd60 + 32'(c.second_out);
        return c;
    endfunction

    function automatic void compare_result(rtc_pkg::t_out got, rtc_pkg::t_out want);
        if (got.second_out !== want.second_out) begin
            $error("second_out expected %0d got %0d", want.second_out, got.second_out);
            had_error = 1'b1;
        end
        if (got.minute_out !== want.minute_out) begin
            $error("minute_out expected %0d got %0d", want.minute_out, got.minute_out);
            had_error = 1'b1;
        end
        if (got.hour_out !== want.hour_out) begin
            $error("hour_out expected %0d got %0d", want.hour_out, got.hour_out);
            had_error = 1'b1;
        end
        if (got.weekday_out !== want.weekday_out) begin
            $error("weekday_out expected %0d got %0d", want.weekday_out, got.weekday_out);
            had_error = 1'b1;
        end
        if (got.day_out !== want.day_out) begin
            $error("day_out expected %0d got %0d", want.day_out, got.day_out);
            had_error = 1'b1;
        end
        if (got.month_out !== want.month_out) begin
            $error("month_out expected %0d got %0d", want.month_out, got.month_out);
            had_error = 1'b1;
        end
        if (got.full_year !== want.full_year) begin
            $error("full_year expected %0d got %0d", want.full_year, got.full_year);
            had_error = 1'b1;
        end
        if (got.seconds_since_2000 !== want.seconds_since_2000) begin
            $error("seconds_since_2000 expected %0d got %0d",
                   want.seconds_since_2000, got.seconds_since_2000);
            had_error = 1'b1;
        end
    endfunction

    // mostly short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // plausible clock readings with random content, plus raw noise
    function automatic rtc_pkg::t_in snapshot_rand(bit bcd, bit h12);
        rtc_pkg::t_in s;
        int           pick;
        if ($urandom_range(99) < 20) begin
            s = {$urandom, $urandom};
            return s;
        end
        s.raw_second  = to_reg($urandom_range(59), bcd);
        s.raw_minute  = to_reg($urandom_range(59), bcd);
        s.raw_weekday = to_reg($urandom_range(1, 7), bcd);
        s.raw_day     = to_reg($urandom_range(1, 31), bcd);
        s.raw_month   = to_reg($urandom_range(1, 12), bcd);
        s.raw_year    = to_reg($urandom_range(99), bcd);
        if (h12)
            s.raw_hour = to_reg($urandom_range(1, 12), bcd) | 8'($urandom_range(1) << 7);
        else
            s.raw_hour = to_reg($urandom_range(23), bcd);
        pick = $urandom_range(3);
        case (pick) inside
            [0:1]:   s.raw_century = to_reg($urandom_range(19, 21), bcd);
            2:       s.raw_century = to_reg($urandom_range(99), bcd);
            default: s.raw_century = 8'($urandom);
        endcase
        return s;
    endfunction

    // returns at the edge where the snapshot transfer happened
    task automatic send_snapshot(rtc_pkg::t_in s, bit typed, rtc_pkg::t_out want);
        int gap;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            gap = idle_len();
            i_valid <= 1'b0;
            i_data  <= {$urandom, $urandom};
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_data    <= s;
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic finish_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (due_calendars.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_mode(bit bcd, bit h12);
        i_cfg_idx   <= rtc_pkg::CFG_BCD_MODE;
        i_cfg_wdata <= bcd;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_idx   <= rtc_pkg::CFG_TWELVE_HOUR;
        i_cfg_wdata <= h12;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_bcd = bcd;
        cfg_h12 = h12;
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat (idle_len()) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        rtc_pkg::t_out want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                want = cur_typed ? cur_want : calendar_of(i_data, cfg_bcd, cfg_h12);
                due_calendars.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (due_calendars.size() == 0) begin
                    $error("result transfer with no snapshot outstanding");
                    had_error = 1'b1;
                end else begin
                    compare_result(o_data, due_calendars.pop_front());
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int p;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= rtc_pkg::CFG_BCD_MODE;
        i_cfg_wdata <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        cur_typed   <= 1'b0;
        cur_want    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct   = 10;
        stall_pct = 10;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].bcd != cfg_bcd || dir_tab[k].h12 != cfg_h12) begin
                finish_burst();
                set_mode(dir_tab[k].bcd, dir_tab[k].h12);
            end
            send_snapshot(dir_tab[k].raw, dir_tab[k].typed, dir_tab[k].want);
        end

        for (p = 0; p < 5; p++) begin
            finish_burst();
            set_mode(phase_bcd[p], phase_h12[p]);
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            // long output hold while snapshots keep coming, fills the pipe
            if (p == 2)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_snapshot(snapshot_rand(cfg_bcd, cfg_h12), 1'b0, NO_WANT);
        end

        finish_burst();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (!had_error && due_calendars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
